// ===== sv/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg: spiral route transposition shared definitions
// Character constants, register indexes and sequencer state types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  // Payload widths
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Character constants
  localparam logic [CHAR_W-1:0] CHAR_X      = 8'h58;  // 'X' padding
  localparam logic [CHAR_W-1:0] CHAR_UA     = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UZ     = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CHAR_LA     = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_LZ     = 8'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;  // lower to upper case
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;  // char of an empty run

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS   = 2'd0,
    REG_REVERSE   = 2'd1,
    REG_DIRECTION = 2'd2,
    REG_STRIP     = 2'd3
  } cfg_reg_e;

  // Main sequencer
  typedef enum logic [2:0] {
    ST_LOAD,     // taking characters
    ST_SIZE,     // row count and capacity, one row per cycle
    ST_START,    // init spiral walker and run length
    ST_SCATTER,  // decrypt: place characters along the spiral
    ST_FLUSH,    // decrypt: last scatter write lands
    ST_READ,     // memory read of the next result
    ST_SEND,     // result on the output channel
    ST_EMPTY     // single empty-run result
  } srt_state_e;

  // Spiral walker leg
  typedef enum logic [1:0] {
    WALK_DOWN,
    WALK_RIGHT,
    WALK_UP,
    WALK_LEFT
  } walk_dir_e;

endpackage : srt_pkg

`default_nettype wire

// ===== sv/srt_in_if.sv =====
// ----------------------------------------------------------------------------
// srt_in_if: input character channel
// Valid/ready channel carrying one message byte and its end marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srt_in_if
  import srt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              last_in;

  modport source (output valid, output char_in, output last_in, input ready);
  modport sink   (input valid, input char_in, input last_in, output ready);
endinterface : srt_in_if

`default_nettype wire

// ===== sv/srt_out_if.sv =====
// ----------------------------------------------------------------------------
// srt_out_if: result character channel
// Valid/ready channel carrying one emitted character and its flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srt_out_if
  import srt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last_out;
  logic              empty_res;
  logic              overflow;

  modport source (output valid, output char_out, output last_out,
                  output empty_res, output overflow, input ready);
  modport sink   (input valid, input char_out, input last_out,
                  input empty_res, input overflow, output ready);
endinterface : srt_out_if

`default_nettype wire

// ===== sv/srt_ram.sv =====
// ----------------------------------------------------------------------------
// srt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : srt_ram

`default_nettype wire

// ===== sv/spiral_route_transposition.sv =====
// ----------------------------------------------------------------------------
// spiral_route_transposition: spiral route transposition cipher
// Loads a message, then emits it read along a counter-clockwise spiral
// (encrypt) or places it back along that spiral (decrypt).
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the block loads a message; in
// encrypt mode only letters are stored (upper-cased), in decrypt mode every
// byte. The transaction that carries last_in starts the run and in_i.ready
// stays low until the run's final result has been taken. The run holds:
// the sizing loop (one add of the column count per matrix row), a setup
// step, in decrypt mode the scatter pass (one spiral step and one store
// read per cycle), then for each result a cell memory read, then its
// presentation, which waits while out_o.ready is held low. The spiral is
// walked by a single walker that steps the cell index by one or by the
// column count, per scatter cycle or per result taken. The result memory
// is written before it is read in a run, and store cells past the characters
// held are read only in place of padding, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spiral_route_transposition
  import srt_pkg::*;
#(
  parameter int CELLS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  srt_in_if.sink                     in_i,
  srt_out_if.source                  out_o
);

  localparam int AW = $clog2(CELLS);      // cell address
  localparam int CW = $clog2(CELLS + 1);  // count of cells, 0..CELLS

  // Configuration registers
  logic [CFG_DATA_W-1:0] columns_q;
  logic                  reverse_q;
  logic                  direction_q;
  logic [5:0]            strip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q   <= 7'd1;
      reverse_q   <= 1'b0;
      direction_q <= 1'b0;
      strip_q     <= 6'd0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COLUMNS:   columns_q   <= cfg_data_i;
        REG_REVERSE:   reverse_q   <= cfg_data_i[0];
        REG_DIRECTION: direction_q <= cfg_data_i[0];
        REG_STRIP:     strip_q     <= cfg_data_i[5:0];
        default:       ;
      endcase
    end
  end

  // Effective column count, clamped to 1..CELLS
  logic [CW-1:0] cols;
  always_comb begin
    if (columns_q == '0) begin
      cols = CW'(1);
    end else if (columns_q > CFG_DATA_W'(CELLS)) begin
      cols = CW'(CELLS);
    end else begin
      cols = CW'(columns_q);
    end
  end

  // Sequencer and datapath registers
  srt_state_e    state_q, state_d;
  logic [CW-1:0] count_q, count_d;   // characters held
  logic          ovf_q, ovf_d;       // a character was dropped
  logic [CW-1:0] acc_q, acc_d;       // cells = rows * cols
  logic [CW-1:0] rows_q, rows_d;
  logic [CW-1:0] len_q, len_d;       // results in this run
  logic [CW-1:0] k_q, k_d;           // step counter
  logic          use_x_q, use_x_d;   // result is padding
  logic          wr_v_q, wr_v_d;     // pending scatter write
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic          wr_x_q, wr_x_d;

  // Spiral walker registers
  walk_dir_e     wdir_q, wdir_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] top_q, top_d;
  logic [CW-1:0] bot_q, bot_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] right_q, right_d;
  logic [AW-1:0] idx_q, idx_d;

  // Memory ports
  logic              store_we;
  logic [AW-1:0]     store_waddr;
  logic [CHAR_W-1:0] store_wdata;
  logic              store_re;
  logic [AW-1:0]     store_raddr;
  logic [CHAR_W-1:0] store_rdata;
  logic              res_re;
  logic [AW-1:0]     res_raddr;
  logic [CHAR_W-1:0] res_rdata;

  srt_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .re_i    (store_re),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  // Spiral-ordered matrix for decrypt; written by the scatter pass
  srt_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (wr_v_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wr_x_q ? CHAR_X : store_rdata),
    .re_i    (res_re),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  // Input character filter
  logic [CHAR_W-1:0] in_char;
  logic              in_keep;
  always_comb begin
    in_char = in_i.char_in;
    in_keep = 1'b1;
    if (!direction_q) begin
      if (in_i.char_in inside {[CHAR_LA:CHAR_LZ]}) begin
        in_char = in_i.char_in - CASE_OFFSET;
      end else if (!(in_i.char_in inside {[CHAR_UA:CHAR_UZ]})) begin
        in_keep = 1'b0;
      end
    end
  end

  // Next spiral step: move along the leg, or turn at its end
  walk_dir_e     adv_wdir;
  logic [CW-1:0] adv_pos, adv_top, adv_bot, adv_left, adv_right;
  logic [AW-1:0] adv_idx;
  logic [AW-1:0] cols_a;
  assign cols_a = cols[AW-1:0];

  always_comb begin
    adv_wdir  = wdir_q;
    adv_pos   = pos_q;
    adv_top   = top_q;
    adv_bot   = bot_q;
    adv_left  = left_q;
    adv_right = right_q;
    adv_idx   = idx_q;
    case (wdir_q)
      WALK_DOWN: begin
        if (pos_q + CW'(1) < bot_q) begin
          adv_pos = pos_q + CW'(1);
          adv_idx = idx_q + cols_a;
        end else begin
          adv_left = left_q + CW'(1);
          adv_wdir = WALK_RIGHT;
          adv_pos  = left_q + CW'(1);
          adv_idx  = idx_q + AW'(1);
        end
      end
      WALK_RIGHT: begin
        if (pos_q + CW'(1) < right_q) begin
          adv_pos = pos_q + CW'(1);
          adv_idx = idx_q + AW'(1);
        end else begin
          adv_bot  = bot_q - CW'(1);
          adv_wdir = WALK_UP;
          adv_pos  = bot_q - CW'(2);
          adv_idx  = idx_q - cols_a;
        end
      end
      WALK_UP: begin
        if (pos_q > top_q) begin
          adv_pos = pos_q - CW'(1);
          adv_idx = idx_q - cols_a;
        end else begin
          adv_right = right_q - CW'(1);
          adv_wdir  = WALK_LEFT;
          adv_pos   = right_q - CW'(2);
          adv_idx   = idx_q - AW'(1);
        end
      end
      WALK_LEFT: begin
        if (pos_q > left_q) begin
          adv_pos = pos_q - CW'(1);
          adv_idx = idx_q - AW'(1);
        end else begin
          adv_top  = top_q + CW'(1);
          adv_wdir = WALK_DOWN;
          adv_pos  = top_q + CW'(1);
          adv_idx  = idx_q + cols_a;
        end
      end
      default: adv_wdir = WALK_DOWN;
    endcase
  end

  // Sizing helpers
  logic [CW:0]   acc_next;
  logic [6:0]    strip_ext;
  logic [6:0]    cells_ext;
  logic [CW-1:0] dec_len;
  assign acc_next  = {1'b0, acc_q} + {1'b0, cols};
  assign strip_ext = {1'b0, strip_q};
  assign cells_ext = 7'(acc_q);
  assign dec_len   = (strip_ext < cells_ext) ? CW'(cells_ext - strip_ext) : '0;

  // Read addresses for the result pass
  logic [AW-1:0] enc_addr;
  logic [AW-1:0] dec_addr;
  logic          run_last;
  assign enc_addr = reverse_q ? AW'(acc_q - CW'(1) - CW'(idx_q)) : idx_q;
  assign dec_addr = reverse_q ? AW'(acc_q - CW'(1) - k_q) : k_q[AW-1:0];
  assign run_last = (k_q + CW'(1) == len_q);

  // Sequencer: next state and outputs
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    acc_d     = acc_q;
    rows_d    = rows_q;
    len_d     = len_q;
    k_d       = k_q;
    use_x_d   = use_x_q;
    wr_v_d    = 1'b0;
    wr_addr_d = wr_addr_q;
    wr_x_d    = wr_x_q;
    wdir_d    = wdir_q;
    pos_d     = pos_q;
    top_d     = top_q;
    bot_d     = bot_q;
    left_d    = left_q;
    right_d   = right_q;
    idx_d     = idx_q;

    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    store_we    = 1'b0;
    store_waddr = count_q[AW-1:0];
    store_wdata = in_char;
    store_re    = 1'b0;
    store_raddr = enc_addr;
    res_re      = 1'b0;
    res_raddr   = dec_addr;

    case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_keep) begin
            if (count_q < CW'(CELLS)) begin
              store_we = 1'b1;
              count_d  = count_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (in_i.last_in) begin
            acc_d   = '0;
            rows_d  = '0;
            state_d = ST_SIZE;
          end
        end
      end

      // Add one row per cycle until the characters fit or room runs out
      ST_SIZE: begin
        if (acc_q < count_q && acc_next <= (CW + 1)'(CELLS)) begin
          acc_d  = acc_next[CW-1:0];
          rows_d = rows_q + CW'(1);
        end else begin
          if (acc_q < count_q) begin
            count_d = acc_q;
            ovf_d   = 1'b1;
          end
          state_d = ST_START;
        end
      end

      ST_START: begin
        wdir_d  = WALK_DOWN;
        pos_d   = '0;
        top_d   = '0;
        bot_d   = rows_q;
        left_d  = '0;
        right_d = cols;
        idx_d   = '0;
        k_d     = '0;
        len_d   = direction_q ? dec_len : acc_q;
        if ((direction_q ? dec_len : acc_q) == '0) begin
          state_d = ST_EMPTY;
        end else if (direction_q) begin
          state_d = ST_SCATTER;
        end else begin
          state_d = ST_READ;
        end
      end

      // Stored character k goes to the k-th spiral cell
      ST_SCATTER: begin
        store_re    = 1'b1;
        store_raddr = k_q[AW-1:0];
        wr_v_d      = 1'b1;
        wr_addr_d   = idx_q;
        wr_x_d      = (k_q >= count_q);
        wdir_d      = adv_wdir;
        pos_d       = adv_pos;
        top_d       = adv_top;
        bot_d       = adv_bot;
        left_d      = adv_left;
        right_d     = adv_right;
        idx_d       = adv_idx;
        if (k_q + CW'(1) == acc_q) begin
          k_d     = '0;
          state_d = ST_FLUSH;
        end else begin
          k_d = k_q + CW'(1);
        end
      end

      ST_FLUSH: begin
        state_d = ST_READ;
      end

      ST_READ: begin
        if (direction_q) begin
          res_re  = 1'b1;
          use_x_d = 1'b0;
        end else begin
          store_re = 1'b1;
          use_x_d  = (CW'(enc_addr) >= count_q);
        end
        state_d = ST_SEND;
      end

      ST_SEND: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          if (run_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            k_d = k_q + CW'(1);
            if (!direction_q) begin
              wdir_d  = adv_wdir;
              pos_d   = adv_pos;
              top_d   = adv_top;
              bot_d   = adv_bot;
              left_d  = adv_left;
              right_d = adv_right;
              idx_d   = adv_idx;
            end
            state_d = ST_READ;
          end
        end
      end

      ST_EMPTY: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end

      default: state_d = ST_LOAD;
    endcase
  end

  // Result payload
  always_comb begin
    if (state_q == ST_EMPTY) begin
      out_o.char_out = CHAR_NONE;
    end else if (use_x_q) begin
      out_o.char_out = CHAR_X;
    end else begin
      out_o.char_out = direction_q ? res_rdata : store_rdata;
    end
    out_o.last_out  = (state_q == ST_EMPTY) || run_last;
    out_o.empty_res = (state_q == ST_EMPTY);
    out_o.overflow  = ovf_q;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      acc_q     <= '0;
      rows_q    <= '0;
      len_q     <= '0;
      k_q       <= '0;
      use_x_q   <= 1'b0;
      wr_v_q    <= 1'b0;
      wr_addr_q <= '0;
      wr_x_q    <= 1'b0;
      wdir_q    <= WALK_DOWN;
      pos_q     <= '0;
      top_q     <= '0;
      bot_q     <= '0;
      left_q    <= '0;
      right_q   <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      acc_q     <= acc_d;
      rows_q    <= rows_d;
      len_q     <= len_d;
      k_q       <= k_d;
      use_x_q   <= use_x_d;
      wr_v_q    <= wr_v_d;
      wr_addr_q <= wr_addr_d;
      wr_x_q    <= wr_x_d;
      wdir_q    <= wdir_d;
      pos_q     <= pos_d;
      top_q     <= top_d;
      bot_q     <= bot_d;
      left_q    <= left_d;
      right_q   <= right_d;
      idx_q     <= idx_d;
    end
  end

endmodule : spiral_route_transposition

`default_nettype wire
